@@ src/rvpg_pkg.sv @@
package rvpg_pkg;

    // request commands
    localparam logic [1:0] CMD_MODE  = 2'd0;
    localparam logic [1:0] CMD_ROM   = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    // display modes
    typedef enum logic [2:0] {
        MODE_TEXT_LO = 3'd0,
        MODE_TEXT_HI = 3'd1,
        MODE_GR_MONO = 3'd2,
        MODE_GR_LO   = 3'd3,
        MODE_GR_HI   = 3'd4
    } t_mode;

    localparam logic [15:0] START_RESET  = 16'h7800;
    localparam logic [7:0]  OFF_LO_MASK  = 8'h3c;
    localparam logic [7:0]  OFF_HI_MASK  = 8'h31;
    localparam logic [7:0]  OFF_TEXT_HI  = 8'h82;
    localparam logic [7:0]  OFF_TEXT_LO  = 8'h02;
    localparam logic [7:0]  OFF_TEXT_SEL = 8'h80;
    localparam logic [7:0]  OFF_MONO_SUB = 8'h03;
    localparam logic [7:0]  OFF_MONO_MSK = 8'h30;
    localparam logic [3:0]  MONO_COLOR   = 4'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  io_offset;
        logic [10:0] rom_index;
        logic [7:0]  rom_data;
        logic [8:0]  pix_x;
        logic [7:0]  pix_y;
        logic [7:0]  ram_byte;
        logic [7:0]  attr_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] fetch_address;
        logic [3:0]  pixel_color;
    } t_out;

endpackage

@@ src/retro_video_pixel_generator_unit.sv @@
// raster pixel generator for a 512x256 screen, five display modes
//
// input channel (i_in_valid / o_in_ready, payload i_in_data) carries three
// kinds of request: a mode select access, a char rom byte load and a pixel
// request with screen x/y plus the video ram and attribute bytes fetched for
// it. every request yields exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out_data): the fetch address and the
// 4-bit palette index of the pixel, zero for non-pixel requests.
//
// an accepted request passes the rom stage, then the output register that
// drives o_out_valid. one stage for the synchronous char rom read (single
// memory port), one for the output register. throughput is one request per
// cycle while the receiver does not stall. mode and rom writes land at
// accept, so a following pixel request already sees them; a rom load and a
// glyph read never share a cycle, so no forwarding is needed.
//
// reset: 32x32 colour text mode, start address 0x7800, pipeline empty.
// char rom contents are not cleared and are undefined until loaded.
// when the receiver stalls, the output register and the rom stage hold;
// o_in_ready drops only once the rom stage is also occupied.
module retro_video_pixel_generator_unit #(
    parameter int CHAR_COUNT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rvpg_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rvpg_pkg::t_out o_out_data
);

    localparam int ROM_DEPTH = CHAR_COUNT * 8;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    // mode registers
    rvpg_pkg::t_mode r_mode;
    rvpg_pkg::t_mode n_mode;
    logic [15:0]     r_start;
    logic [15:0]     n_start;
    logic [7:0]      sel_diff;

    // char rom
    logic [7:0]        mem [ROM_DEPTH];
    logic [7:0]        r_rom_q;
    logic              rom_wr_ok;
    logic [8:0]        code_ext;
    logic [10:0]       rd_full;
    logic [ROM_AW-1:0] rd_addr;

    // rom stage
    logic            r_s1_valid;
    logic [15:0]     r_s1_addr;
    logic            r_s1_text;
    logic            r_s1_on;
    logic [3:0]      r_s1_fg;
    logic [2:0]      r_s1_col;
    logic [3:0]      r_s1_gcolor;
    logic [15:0]     n_s1_addr;
    logic            n_s1_text;
    logic            n_s1_on;
    logic [3:0]      n_s1_fg;
    logic [2:0]      n_s1_col;
    logic [3:0]      n_s1_gcolor;
    logic [15:0]     pix_off;

    // output stage
    logic            r_out_valid;
    rvpg_pkg::t_out  r_out_data;
    logic            s1_lit;
    logic [3:0]      s1_color;

    logic in_acc;
    logic s1_go;
    logic is_pix;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_pix     = (i_in_data.cmd == rvpg_pkg::CMD_PIXEL);

    // mode select decode: offset bits 1:0 pick the mode (text above 0x80 is hi),
    // start comes from a per-mode offset expression shifted up by 9
    always_comb begin
        n_mode   = rvpg_pkg::MODE_GR_MONO;
        sel_diff = '0;
        case (i_in_data.io_offset[1:0])
            2'd0: begin
                n_mode   = rvpg_pkg::MODE_GR_LO;
                sel_diff = i_in_data.io_offset & rvpg_pkg::OFF_LO_MASK;
            end
            2'd1: begin
                n_mode   = rvpg_pkg::MODE_GR_HI;
                sel_diff = (i_in_data.io_offset & rvpg_pkg::OFF_HI_MASK) - 8'd1;
            end
            2'd2: begin
                if (i_in_data.io_offset > rvpg_pkg::OFF_TEXT_SEL) begin
                    n_mode   = rvpg_pkg::MODE_TEXT_HI;
                    sel_diff = i_in_data.io_offset - rvpg_pkg::OFF_TEXT_HI;
                end else begin
                    n_mode   = rvpg_pkg::MODE_TEXT_LO;
                    sel_diff = i_in_data.io_offset - rvpg_pkg::OFF_TEXT_LO;
                end
            end
            default: begin
                n_mode   = rvpg_pkg::MODE_GR_MONO;
                sel_diff = (i_in_data.io_offset - rvpg_pkg::OFF_MONO_SUB)
                           & rvpg_pkg::OFF_MONO_MSK;
            end
        endcase
        // only the low 7 bits survive the shift into 16 bits
        n_start = {sel_diff[6:0], 9'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= rvpg_pkg::MODE_TEXT_LO;
            r_start <= rvpg_pkg::START_RESET;
        end else if (in_acc && i_in_data.cmd == rvpg_pkg::CMD_MODE) begin
            r_mode  <= n_mode;
            r_start <= n_start;
        end
    end

    // glyph address: char code folded into the rom (code < 2*CHAR_COUNT),
    // then code*8 + glyph row
    always_comb begin
        code_ext = {1'b0, i_in_data.ram_byte};
        if (code_ext >= 9'(CHAR_COUNT)) begin
            code_ext = code_ext - 9'(CHAR_COUNT);
        end
        rd_full   = {code_ext[7:0], i_in_data.pix_y[2:0]};
        rd_addr   = rd_full[ROM_AW-1:0];
        rom_wr_ok = ({1'b0, i_in_data.rom_index} < 12'(ROM_DEPTH));
    end

    // single-port char rom: a load request writes, a pixel request reads
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.cmd == rvpg_pkg::CMD_ROM) begin
            if (rom_wr_ok) begin
                mem[i_in_data.rom_index[ROM_AW-1:0]] <= i_in_data.rom_data;
            end
        end else if (in_acc && is_pix) begin
            r_rom_q <= mem[rd_addr];
        end
    end

    // per-mode address offset and everything but the glyph bit
    always_comb begin
        pix_off     = '0;
        n_s1_text   = 1'b0;
        n_s1_on     = 1'b0;
        n_s1_fg     = '0;
        n_s1_col    = '0;
        n_s1_gcolor = '0;
        case (r_mode)
            rvpg_pkg::MODE_TEXT_LO: begin
                pix_off   = 16'({i_in_data.pix_x[8:4], 1'b0})
                          + 16'({i_in_data.pix_y[7:3], 6'd0});
                n_s1_text = 1'b1;
                n_s1_col  = i_in_data.pix_x[3:1];
                n_s1_fg   = {i_in_data.attr_byte[4], i_in_data.attr_byte[2:0]};
                // attribute bit 5 set: lit pixels take the foreground
                n_s1_on   = i_in_data.attr_byte[5];
            end
            rvpg_pkg::MODE_TEXT_HI: begin
                pix_off   = 16'(i_in_data.pix_x[8:3])
                          + 16'({i_in_data.pix_y[7:3], 6'd0});
                n_s1_text = 1'b1;
                n_s1_col  = i_in_data.pix_x[2:0];
                n_s1_fg   = rvpg_pkg::MONO_COLOR;
                // polarity from start address bit 11
                n_s1_on   = r_start[11];
            end
            rvpg_pkg::MODE_GR_HI: begin
                pix_off     = 16'(i_in_data.pix_x[8:3])
                            + 16'({i_in_data.pix_y[7:1], 6'd0});
                n_s1_gcolor = i_in_data.pix_x[2] ? i_in_data.ram_byte[3:0]
                                                 : i_in_data.ram_byte[7:4];
            end
            rvpg_pkg::MODE_GR_LO: begin
                pix_off     = 16'(i_in_data.pix_x[8:4])
                            + 16'({i_in_data.pix_y[7:2], 5'd0});
                n_s1_gcolor = i_in_data.pix_x[3] ? i_in_data.ram_byte[3:0]
                                                 : i_in_data.ram_byte[7:4];
            end
            default: begin
                pix_off     = 16'(i_in_data.pix_x[8:4])
                            + 16'({i_in_data.pix_y, 5'd0});
                n_s1_gcolor = i_in_data.ram_byte[3'd7 - i_in_data.pix_x[3:1]]
                            ? rvpg_pkg::MONO_COLOR : 4'd0;
            end
        endcase
        n_s1_addr = r_start + pix_off;
        // non-pixel requests return an all-zero result
        if (!is_pix) begin
            n_s1_addr   = '0;
            n_s1_text   = 1'b0;
            n_s1_gcolor = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= n_s1_addr;
            r_s1_text   <= n_s1_text;
            r_s1_on     <= n_s1_on;
            r_s1_fg     <= n_s1_fg;
            r_s1_col    <= n_s1_col;
            r_s1_gcolor <= n_s1_gcolor;
        end
        if (s1_go) begin
            r_out_data.fetch_address <= r_s1_addr;
            r_out_data.pixel_color   <= s1_color;
        end
    end

    // glyph bit 7 is the leftmost column
    assign s1_lit   = r_rom_q[3'd7 - r_s1_col];
    assign s1_color = r_s1_text ? ((s1_lit == r_s1_on) ? r_s1_fg : 4'd0)
                                : r_s1_gcolor;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an empty rom stage always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled with empty rom stage");

    // start address from a mode access is always a multiple of 512
    a_start_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.cmd == rvpg_pkg::CMD_MODE) |=> (r_start[8:0] == 9'd0))
        else $error("start address not aligned");

    // offset bits 1:0 of zero select 64x64 nibble colour
    a_mode_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.cmd == rvpg_pkg::CMD_MODE
         && i_in_data.io_offset[1:0] == 2'd0) |=> (r_mode == rvpg_pkg::MODE_GR_LO))
        else $error("mode select decode wrong");

    // non-pixel requests carry a zero result into the rom stage
    a_nonpix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_pix) |=> (r_s1_addr == 16'd0 && !r_s1_text
                                 && r_s1_gcolor == 4'd0))
        else $error("non-pixel result not zero");

endmodule
